[rtl/core/cidf_pkg.sv]
// package: shared types and constants for the can identifier range filter table
`default_nettype none
package cidf_pkg;

	localparam int unsigned ID_W     = 29;
	localparam int unsigned DLC_W    = 4;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned RIU_W    = 4;

	localparam logic [DLC_W-1:0] DLC_MIN = DLC_W'(1);
	localparam logic [DLC_W-1:0] DLC_MAX = DLC_W'(8);

	localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_COVERED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	// item fields held for the whole walk, broadcast to every cell
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   frame_id;
		logic [DLC_W-1:0]  frame_dlc;
		logic [ID_W-1:0]   range_low;
		logic [ID_W-1:0]   range_high;
	} item_t;

	// token handed from cell to cell, collecting what the slots saw
	typedef struct packed {
		logic vld;
		logic hit;
		logic covered;
		logic free_seen;
		logic match_seen;
	} rec_t;

	// table update broadcast at the end of the walk
	typedef struct packed {
		logic add_go;
		logic del_go;
	} cmd_t;

endpackage
`default_nettype wire

[rtl/core/cidf_in_if.sv]
// interface: input channel carrying check, add and remove items
`default_nettype none
interface cidf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [28:0] frame_id;
	logic [3:0]  frame_dlc;
	logic [28:0] range_low;
	logic [28:0] range_high;

	modport source (output valid, kind, frame_id, frame_dlc, range_low, range_high,
		input ready);
	modport sink (input valid, kind, frame_id, frame_dlc, range_low, range_high,
		output ready);
endinterface
`default_nettype wire

[rtl/core/cidf_out_if.sv]
// interface: result channel
`default_nettype none
interface cidf_out_if;
	logic       valid;
	logic       ready;
	logic       accept;
	logic [2:0] status;
	logic [3:0] ranges_in_use;

	modport source (output valid, accept, status, ranges_in_use, input ready);
	modport sink (input valid, accept, status, ranges_in_use, output ready);
endinterface
`default_nettype wire

[rtl/core/cidf_cell.sv]
// module: one table slot and its stage of the token chain
`default_nettype none
module cidf_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cidf_pkg::item_t item,
	input  wire cidf_pkg::rec_t  rec_in,
	output cidf_pkg::rec_t      rec_out,
	input  wire cidf_pkg::cmd_t  cmd
);
	import cidf_pkg::*;

	logic            used_q;
	logic [ID_W-1:0] low_q;
	logic [ID_W-1:0] high_q;
	logic            take_free_q;
	logic            take_match_q;
	logic            hit;
	logic            cov;
	logic            match;
	logic            free;
	rec_t            rec_nx;

	always_comb begin
		hit   = used_q && (item.frame_id >= low_q) && (item.frame_id <= high_q);
		cov   = used_q && (item.range_low >= low_q) && (item.range_high <= high_q);
		match = used_q && (item.range_low == low_q) && (item.range_high == high_q);
		free  = !used_q;
		rec_nx            = rec_in;
		rec_nx.hit        = rec_in.hit | hit;
		rec_nx.covered    = rec_in.covered | cov;
		rec_nx.free_seen  = rec_in.free_seen | free;
		rec_nx.match_seen = rec_in.match_seen | match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_out      <= '0;
			take_free_q  <= 1'b0;
			take_match_q <= 1'b0;
		end else begin
			rec_out <= rec_nx;
			// first free / first matching slot claims itself as the token passes
			if (rec_in.vld) begin
				take_free_q  <= free && !rec_in.free_seen;
				take_match_q <= match && !rec_in.match_seen;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (cmd.add_go && take_free_q) begin
			used_q <= 1'b1;
		end else if (cmd.del_go && take_match_q) begin
			used_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_go && take_free_q) begin
			low_q  <= item.range_low;
			high_q <= item.range_high;
		end
	end

endmodule
`default_nettype wire

[rtl/core/can_id_range_filter_table.sv]
// CAN identifier range filter table: top level with the row of slot cells
//
// Items arrive on the in channel: kind 0 checks a frame (frame_id, frame_dlc)
// against the stored ranges, kind 1 adds a range, kind 2 removes an exact range.
// Every item gives one beat on the out channel with accept, status and the
// number of ranges in use after the item.
// An accepted item starts a token at slot 0 that moves one slot per cycle
// along the row of SLOTS cells, gathering hit, cover, free and match flags.
// When it leaves the last cell the result is formed and the chosen slot is
// written or freed as the result beat is registered. One item is in flight
// at a time: the next input beat is taken only after the previous result
// is committed at the end of its token walk.
// A finished result sits in the output register; while the receiver stalls
// a new item can still be accepted and walk the chain, and only its table
// update waits until the pending beat is taken.
// Reset empties every slot and clears the count; no clearing pass is needed.
`default_nettype none
module can_id_range_filter_table #(
	parameter int unsigned SLOTS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cidf_in_if.sink   in,
	cidf_out_if.source out
);
	import cidf_pkg::*;

	localparam int unsigned CNT_W = $clog2(SLOTS + 1);

	item_t            item_q;
	logic             busy_q;
	logic             start_q;
	rec_t             fin_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nx;
	logic [31:0]      count_ext;
	logic             ov_q;
	logic             acc_q;
	logic [STATUS_W-1:0] st_q;
	logic [RIU_W-1:0] riu_q;

	logic             in_fire;
	logic             commit;
	logic             invalid;
	logic             res_acc;
	logic [STATUS_W-1:0] res_st;
	cmd_t             cmd;
	rec_t             chain [SLOTS+1];

	assign in_fire  = in.valid && in.ready;
	assign in.ready = !busy_q;
	assign commit   = fin_q.vld && (!ov_q || out.ready);
	assign invalid  = item_q.range_low > item_q.range_high;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q.kind       <= in.kind;
			item_q.frame_id   <= in.frame_id;
			item_q.frame_dlc  <= in.frame_dlc;
			item_q.range_low  <= in.range_low;
			item_q.range_high <= in.range_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
			fin_q   <= '0;
		end else begin
			start_q <= in_fire;
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (chain[SLOTS].vld) begin
				fin_q <= chain[SLOTS];
			end else if (commit) begin
				fin_q <= '0;
			end
		end
	end

	always_comb begin
		chain[0]     = '0;
		chain[0].vld = start_q;
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		cidf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.item    (item_q),
			.rec_in  (chain[g]),
			.rec_out (chain[g+1]),
			.cmd     (cmd)
		);
	end

	// result decode and table update
	always_comb begin
		res_acc    = 1'b0;
		res_st     = ST_DONE;
		cmd.add_go = 1'b0;
		cmd.del_go = 1'b0;
		count_nx   = count_q;
		unique case (item_q.kind)
			KIND_CHECK: begin
				res_acc = (count_q == '0) ||
					((item_q.frame_dlc >= DLC_MIN) && (item_q.frame_dlc <= DLC_MAX) &&
					fin_q.hit);
			end
			KIND_ADD: begin
				if (invalid) begin
					res_st = ST_INVALID;
				end else if (fin_q.covered) begin
					res_st = ST_COVERED;
				end else if (fin_q.free_seen) begin
					cmd.add_go = commit;
					count_nx   = count_q + CNT_W'(1);
				end else begin
					res_st = ST_FULL;
				end
			end
			KIND_REMOVE: begin
				if (invalid) begin
					res_st = ST_INVALID;
				end else if (fin_q.match_seen) begin
					cmd.del_go = commit;
					count_nx   = count_q - CNT_W'(1);
				end else begin
					res_st = ST_NOT_FOUND;
				end
			end
			default: begin
				res_st = ST_DONE;
			end
		endcase
		count_ext = 32'(count_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (commit) begin
				count_q <= count_nx;
				ov_q    <= 1'b1;
			end else if (out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			acc_q <= res_acc;
			st_q  <= res_st;
			riu_q <= count_ext[RIU_W-1:0];
		end
	end

	assign out.valid         = ov_q;
	assign out.accept        = acc_q;
	assign out.status        = st_q;
	assign out.ranges_in_use = riu_q;

endmodule
`default_nettype wire

[rtl/core/cidf_chk.sv]
// module: port-level assertions for the filter table, bound to the top level
`default_nettype none
module cidf_chk #(
	parameter int unsigned SLOTS = 8
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       out_accept,
	input wire logic [2:0] out_status,
	input wire logic [3:0] out_ranges_in_use
);
	import cidf_pkg::*;

	// only one item walks the chain at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a result needs the full walk, never right after its input beat
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared one cycle after input beat");

	// a passing frame is always a check with a clean status
	a_accept_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_accept) |-> (out_status == ST_DONE))
		else $error("accept with nonzero status");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_accept) &&
		$stable(out_status) && $stable(out_ranges_in_use)))
		else $error("stalled result beat changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((SLOTS > 15) || (32'(out_ranges_in_use) <= SLOTS)))
		else $error("ranges in use beyond slot count");

endmodule

bind can_id_range_filter_table cidf_chk #(.SLOTS(SLOTS)) u_cidf_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in.valid),
	.in_ready          (in.ready),
	.out_valid         (out.valid),
	.out_ready         (out.ready),
	.out_accept        (out.accept),
	.out_status        (out.status),
	.out_ranges_in_use (out.ranges_in_use)
);
`default_nettype wire
